@@ sv/srfb_pkg.sv @@
`timescale 1ns / 1ps
// Package for the shape rasterizer frame buffer.
// Holds payload structs, command kinds, queue entry and sequencer state types.
package srfb_pkg;

	localparam int CANVAS_ROWS_DEF = 32;
	localparam int CANVAS_COLS_DEF = 64;

	// Command kinds.
	localparam logic [2:0] KIND_CLEAR  = 3'd0;
	localparam logic [2:0] KIND_CIRCLE = 3'd1;
	localparam logic [2:0] KIND_RECT   = 3'd2;
	localparam logic [2:0] KIND_LINE   = 3'd3;
	localparam logic [2:0] KIND_TRI    = 3'd4;
	localparam logic [2:0] KIND_READ   = 3'd5;

	typedef struct packed {
		logic [2:0] kind;
		logic [5:0] ax;
		logic [4:0] ay;
		logic [5:0] bx;
		logic [4:0] by_coord;
		logic [5:0] cx_third;
		logic [4:0] cy_third;
		logic [5:0] radius;
		logic [6:0] rect_width;
		logic [5:0] rect_height;
	} cmd_t;

	typedef struct packed {
		logic [63:0] row_bits;
		logic        is_read;
	} result_t;

	// Classified operation handed from the front end to the back end.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_CIRCLE,
		OP_RECT,
		OP_LINE,
		OP_TRI,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t  op;
		cmd_t cmd;
	} job_t;

	// Back end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_LINE_SETUP,
		ST_LINE,
		ST_RECT,
		ST_CIRC,
		ST_READ,
		ST_READ_WAIT,
		ST_PLOT_RD,
		ST_PLOT_WR,
		ST_DONE
	} state_t;

endpackage

@@ sv/srfb_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts command transactions, classifies them, queues them.
// Depends on srfb_pkg.
module srfb_front import srfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_data,
	output logic job_valid,
	input  logic job_ready,
	output job_t job
);
	localparam int DEPTH = 2;

	job_t       mem_q [DEPTH];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	op_t        op;

	// Map the command kind to an operation.
	always_comb begin
		case (in_data.kind)
			KIND_CLEAR:  op = OP_CLEAR;
			KIND_CIRCLE: op = OP_CIRCLE;
			KIND_RECT:   op = OP_RECT;
			KIND_LINE:   op = OP_LINE;
			KIND_TRI:    op = OP_TRI;
			KIND_READ:   op = OP_READ;
			default:     op = OP_NONE;
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = mem_q[rd_q];

	// Two-entry queue between front and back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (job_valid && job_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, job_valid && job_ready};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wr_q] <= '{op: op, cmd: in_data};
	end
endmodule

@@ sv/srfb_back.sv @@
`timescale 1ns / 1ps
// Back end: walks shapes pixel by pixel into the row memory and answers reads.
// Depends on srfb_pkg.
module srfb_back import srfb_pkg::*; #(
	parameter int CANVAS_ROWS = CANVAS_ROWS_DEF,
	parameter int CANVAS_COLS = CANVAS_COLS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_valid,
	output logic    job_ready,
	input  job_t    job,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);
	localparam int RW = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;

	// Row memory, one word per row.
	logic [63:0] mem [CANVAS_ROWS];
	logic [63:0] rdata_q;

	state_t st_q, st_d;
	cmd_t   cmd_q;
	op_t    op_q;
	logic   out_valid_q;
	logic   boot_q;
	result_t out_q;

	// Shape walker registers (signed, wide enough for all offsets).
	logic signed [9:0]  x_q, y_q, x1_q, y1_q, dx_q, dy_q, sx_q, sy_q;
	logic signed [11:0] err_q;
	logic [1:0]         seg_q;
	logic signed [9:0]  ca_q, cb_q;
	logic signed [12:0] cd_q;
	logic [2:0]         oct_q;
	logic [7:0]         idx_q;
	logic [2:0]         rph_q;
	logic [RW:0]        clr_q;
	logic signed [9:0]  px_q, py_q;
	state_t             ret_q;

	// Pixel position for the current circle octant.
	logic signed [9:0] ox, oy;
	always_comb begin
		case (oct_q)
			3'd0: begin ox = ca_q;  oy = cb_q;  end
			3'd1: begin ox = -ca_q; oy = cb_q;  end
			3'd2: begin ox = ca_q;  oy = -cb_q; end
			3'd3: begin ox = -ca_q; oy = -cb_q; end
			3'd4: begin ox = cb_q;  oy = ca_q;  end
			3'd5: begin ox = -cb_q; oy = ca_q;  end
			3'd6: begin ox = cb_q;  oy = -ca_q; end
			default: begin ox = -cb_q; oy = -ca_q; end
		endcase
	end

	// Rectangle edge pixel for phase and index.
	logic signed [9:0] rx, ry;
	logic signed [9:0] rl, rt, rw, rh;
	always_comb begin
		rl = {4'd0, cmd_q.ax};
		rt = {5'd0, cmd_q.ay};
		rw = {3'd0, cmd_q.rect_width};
		rh = {4'd0, cmd_q.rect_height};
		case (rph_q)
			3'd0: begin rx = rl + $signed({2'd0, idx_q}); ry = rt; end
			3'd1: begin rx = rl + $signed({2'd0, idx_q}); ry = rt + rh - 10'sd1; end
			3'd2: begin rx = rl; ry = rt + $signed({2'd0, idx_q}); end
			default: begin rx = rl + rw - 10'sd1; ry = rt + $signed({2'd0, idx_q}); end
		endcase
	end

	logic in_canvas;
	assign in_canvas = (px_q >= 0) && (px_q < CANVAS_COLS) && (px_q < 64)
		&& (py_q >= 0) && (py_q < CANVAS_ROWS);

	// Line step decisions from the doubled error term, all compared as signed values.
	logic signed [12:0] e2;
	logic signed [12:0] dx13, dy13;
	logic               step_x, step_y;
	assign e2     = {err_q[11], err_q} <<< 1;
	assign dx13   = 13'(dx_q);
	assign dy13   = 13'(dy_q);
	assign step_x = (e2 > -dy13);
	assign step_y = (e2 < dx13);

	// Row index of a row read: the five-bit row coordinate zero-extended to ten bits.
	logic [9:0] rd_row;
	assign rd_row = {5'd0, cmd_q.ay};

	assign job_ready = (st_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (job_valid && job_ready) begin
				case (job.op)
					OP_CLEAR:  st_d = ST_CLEAR;
					OP_CIRCLE: st_d = ST_CIRC;
					OP_RECT:   st_d = ST_RECT;
					OP_LINE, OP_TRI: st_d = ST_LINE_SETUP;
					OP_READ:   st_d = ST_READ;
					default:   st_d = ST_DONE;
				endcase
			end
			default: ;
		endcase
	end

	// Segment endpoints of a triangle.
	function automatic logic signed [9:0] vx(input cmd_t c, input logic [1:0] s);
		case (s)
			2'd0: vx = {4'd0, c.ax};
			2'd1: vx = {4'd0, c.bx};
			default: vx = {4'd0, c.cx_third};
		endcase
	endfunction
	function automatic logic signed [9:0] vy(input cmd_t c, input logic [1:0] s);
		case (s)
			2'd0: vy = {5'd0, c.ay};
			2'd1: vy = {5'd0, c.by_coord};
			default: vy = {5'd0, c.cy_third};
		endcase
	endfunction

	// Sequencer: each pixel is a read-modify-write of its row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			out_valid_q <= 1'b0;
			clr_q       <= '0;
			op_q        <= OP_CLEAR;
			boot_q      <= 1'b1;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (job_valid && job_ready) begin
					cmd_q <= job.cmd;
					op_q  <= job.op;
					clr_q <= '0;
					seg_q <= 2'd0;
					idx_q <= '0;
					rph_q <= '0;
					ca_q  <= '0;
					cb_q  <= {4'd0, job.cmd.radius};
					cd_q  <= 13'sd3 - ({7'd0, job.cmd.radius} <<< 1);
					oct_q <= '0;
					st_q  <= st_d;
				end
				ST_CLEAR: begin
					// The clearing pass after reset answers nothing.
					if (clr_q == (RW+1)'(CANVAS_ROWS - 1)) begin
						st_q   <= boot_q ? ST_IDLE : ST_DONE;
						boot_q <= 1'b0;
					end
					clr_q <= clr_q + 1'b1;
				end
				ST_LINE_SETUP: begin
					// A line uses segment zero, whose end point is the second vertex.
					x_q  <= vx(cmd_q, seg_q);
					y_q  <= vy(cmd_q, seg_q);
					x1_q <= (seg_q == 2'd2) ? vx(cmd_q, 2'd0) : vx(cmd_q, seg_q + 2'd1);
					y1_q <= (seg_q == 2'd2) ? vy(cmd_q, 2'd0) : vy(cmd_q, seg_q + 2'd1);
					st_q <= ST_LINE;
					idx_q <= 8'd0;
				end
				ST_LINE: begin
					// The first pass after setup computes the deltas and plots the start point; later passes step.
					if (idx_q == 8'd0) begin
						dx_q  <= (x1_q > x_q) ? x1_q - x_q : x_q - x1_q;
						dy_q  <= (y1_q > y_q) ? y1_q - y_q : y_q - y1_q;
						sx_q  <= (x_q < x1_q) ? 10'sd1 : -10'sd1;
						sy_q  <= (y_q < y1_q) ? 10'sd1 : -10'sd1;
						err_q <= 12'((x1_q > x_q) ? x1_q - x_q : x_q - x1_q)
							- 12'((y1_q > y_q) ? y1_q - y_q : y_q - y1_q);
						idx_q <= 8'd1;
						px_q <= x_q; py_q <= y_q;
						ret_q <= ST_LINE;
						st_q  <= ST_PLOT_RD;
					end else if (x_q == x1_q && y_q == y1_q) begin
						if (op_q == OP_TRI && seg_q != 2'd2) begin
							seg_q <= seg_q + 2'd1;
							st_q  <= ST_LINE_SETUP;
						end else begin
							st_q <= ST_DONE;
						end
					end else begin
						if (step_x) begin
							x_q <= x_q + sx_q;
						end
						if (step_y) begin
							y_q <= y_q + sy_q;
						end
						err_q <= err_q - (step_x ? 12'(dy_q) : 12'sd0)
							+ (step_y ? 12'(dx_q) : 12'sd0);
						px_q <= x_q + (step_x ? sx_q : 10'sd0);
						py_q <= y_q + (step_y ? sy_q : 10'sd0);
						ret_q <= ST_LINE;
						st_q  <= ST_PLOT_RD;
					end
				end
				ST_RECT: begin
					if ((rph_q < 3'd2 && {1'b0, idx_q} >= {2'd0, cmd_q.rect_width})
						|| (rph_q >= 3'd2 && {1'b0, idx_q} >= {3'd0, cmd_q.rect_height})) begin
						idx_q <= '0;
						if (rph_q == 3'd3) st_q <= ST_DONE;
						rph_q <= rph_q + 3'd1;
					end else begin
						px_q  <= rx; py_q <= ry;
						idx_q <= idx_q + 8'd1;
						ret_q <= ST_RECT;
						st_q  <= ST_PLOT_RD;
					end
				end
				ST_CIRC: begin
					// Eight octant pixels, then one midpoint step.
					px_q  <= {4'd0, cmd_q.ax} + ox;
					py_q  <= {5'd0, cmd_q.ay} + oy;
					oct_q <= oct_q + 3'd1;
					ret_q <= (oct_q == 3'd7 && cb_q < ca_q) ? ST_DONE : ST_CIRC;
					st_q  <= ST_PLOT_RD;
					if (oct_q == 3'd7 && !(cb_q < ca_q)) begin
						ca_q <= ca_q + 10'sd1;
						if (cd_q > 0) begin
							cb_q <= cb_q - 10'sd1;
							cd_q <= cd_q + ((13'(ca_q) + 13'sd1 - 13'(cb_q) + 13'sd1) <<< 2)
								+ 13'sd10;
						end else begin
							cd_q <= cd_q + ((13'(ca_q) + 13'sd1) <<< 2) + 13'sd6;
						end
					end
				end
				ST_PLOT_RD: st_q <= ST_PLOT_WR;
				ST_PLOT_WR: st_q <= ret_q;
				ST_READ: st_q <= ST_READ_WAIT;
				ST_READ_WAIT: begin
					out_q.is_read  <= 1'b1;
					out_q.row_bits <= ({2'd0, cmd_q.ay} < CANVAS_ROWS) ? rdata_q : 64'd0;
					out_valid_q    <= 1'b1;
					st_q           <= ST_IDLE;
				end
				ST_DONE: begin
					// Every command that is not a row read answers with zero.
					out_q.is_read  <= 1'b0;
					out_q.row_bits <= 64'd0;
					out_valid_q    <= 1'b1;
					st_q           <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Row memory read and write ports.
	always_ff @(posedge clk) begin
		if (st_q == ST_READ)
			rdata_q <= mem[rd_row[RW-1:0]];
		else if (st_q == ST_PLOT_RD)
			rdata_q <= mem[py_q[RW-1:0]];
		if (st_q == ST_CLEAR)
			mem[clr_q[RW-1:0]] <= 64'd0;
		else if (st_q == ST_PLOT_WR && in_canvas)
			mem[py_q[RW-1:0]] <= rdata_q | (64'd1 << px_q[5:0]);
	end
endmodule

@@ sv/shape_rasterizer_frame_buffer.sv @@
`timescale 1ns / 1ps
// Top level of the one-bit shape rasterizer frame buffer.
// Depends on srfb_pkg, srfb_front and srfb_back.
// Every command returns one result. The canvas is a row memory of CANVAS_ROWS 64-bit
// words; after reset a clearing pass over all CANVAS_ROWS rows runs before the first
// command is taken, and a clear command runs the same pass. Each plotted pixel is a
// read-modify-write of its row, done in a read state followed by a write state. A
// two-entry queue lets commands be accepted while the back end works.
module shape_rasterizer_frame_buffer import srfb_pkg::*; #(
	parameter int CANVAS_ROWS = CANVAS_ROWS_DEF,
	parameter int CANVAS_COLS = CANVAS_COLS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  cmd_t    in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);
	logic job_valid, job_ready;
	job_t job;

	srfb_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.job_valid, .job_ready, .job
	);

	srfb_back #(.CANVAS_ROWS(CANVAS_ROWS), .CANVAS_COLS(CANVAS_COLS)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.out_valid, .out_ready, .out_data
	);
endmodule
